// ===== hw/rtl/voxel_rotate_forward_map_defines.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the voxel rotate forward map block
// ----------------------------------------------------------------------------
`ifndef VOXEL_ROTATE_FORWARD_MAP_DEFINES_SVH
`define VOXEL_ROTATE_FORWARD_MAP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define VRFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define VRFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vrfm_pkg.sv =====
// ----------------------------------------------------------------------------
// vrfm_pkg
// shared types and constants for the voxel rotate forward map block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrfm_pkg;

    // store geometry
    localparam int VOL_DIM    = 32;
    localparam int VOXEL_BITS = 16;
    localparam int VAL_W      = (VOXEL_BITS < 16) ? VOXEL_BITS : 16;
    localparam int STORE_SIZE = VOL_DIM * VOL_DIM * VOL_DIM;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int OFF_W      = (VOL_DIM > 2) ? $clog2(VOL_DIM) : 1;

    // arithmetic widths
    localparam int COORD_W = 16;
    localparam int COEF_W  = 16;
    localparam int PIV_W   = 20;
    localparam int Q_W     = 20;
    localparam int D_W     = 21;
    localparam int PROD_W  = 37;
    localparam int SUM_W   = 38;
    localparam int FRAC_SH = 18;
    localparam int PIV_SH  = 14;
    localparam int ROW_W   = 48;
    localparam int PIVOT_W = 60;
    localparam int CFG_W   = 60;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [2:0]              t_coord_vec;
    typedef logic signed [Q_W-1:0]     t_q;
    typedef t_q [2:0]                  t_q_vec;
    typedef logic [2:0][ROW_W-1:0]     t_rows;

    typedef enum logic [2:0] {
        STAT_PLACED    = 3'd0,
        STAT_SRC_EMPTY = 3'd1,
        STAT_OUTSIDE   = 3'd2,
        STAT_OCCUPIED  = 3'd3,
        STAT_READ_DONE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_ROT_X   = 3'd0,
        CFG_ROT_Y   = 3'd1,
        CFG_ROT_Z   = 3'd2,
        CFG_PIVOT   = 3'd3,
        CFG_LOWER   = 3'd4,
        CFG_UPPER   = 3'd5,
        CFG_EMPTY   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XFORM,
        ST_CHECK,
        ST_ADDR,
        ST_MERGE
    } t_state;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [15:0]               src_value;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic signed [COORD_W-1:0] dest_z;
        logic [15:0]               voxel_out;
    } t_out_item;

endpackage

// ===== hw/rtl/vrfm_xform.sv =====
// ----------------------------------------------------------------------------
// vrfm_xform
// five-stage pipeline: q = trunc((R * (16p - pivot) + pivot * 2^14) / 2^18)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrfm_xform (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vrfm_pkg::t_coord_vec i_pos,
    input  vrfm_pkg::t_rows      i_rot,
    input  logic [59:0]          i_pivot,
    output logic                 o_done,
    output vrfm_pkg::t_q_vec     o_q
);
    import vrfm_pkg::*;

    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_SH) - 1);

    logic [4:0] r_vld;

    logic signed [D_W-1:0]    r_d    [3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [SUM_W-1:0]  r_a    [3];
    logic signed [SUM_W-1:0]  r_b    [3];
    logic signed [SUM_W-1:0]  r_t    [3];
    logic signed [Q_W-1:0]    r_q    [3];

    logic signed [D_W-1:0]    d_c    [3];
    logic signed [PROD_W-1:0] prod_c [3][3];
    logic signed [SUM_W-1:0]  a_c    [3];
    logic signed [SUM_W-1:0]  b_c    [3];
    logic signed [SUM_W-1:0]  t_c    [3];
    logic signed [Q_W-1:0]    q_c    [3];

    always_comb begin
        logic signed [PIV_W-1:0]        piv    [3];
        logic signed [PIV_W-1:0]        p16    [3];
        logic signed [PIV_W+PIV_SH-1:0] piv14  [3];
        logic signed [COEF_W-1:0]       coef   [3][3];
        logic signed [SUM_W-1:0]        biased [3];
        for (int a = 0; a < 3; a++) begin
            piv[a]   = i_pivot[PIV_W*a +: PIV_W];
            p16[a]   = {i_pos[a], 4'd0};
            piv14[a] = {piv[a], {PIV_SH{1'b0}}};
            d_c[a]   = D_W'(p16[a]) - D_W'(piv[a]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c]   = i_rot[r][COEF_W*c +: COEF_W];
                prod_c[r][c] = PROD_W'(coef[r][c]) * PROD_W'(r_d[c]);
            end
            a_c[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]);
            b_c[r] = SUM_W'(r_prod[r][2]) + SUM_W'(piv14[r]);
            t_c[r] = r_a[r] + r_b[r];
            // bias negatives so the shift truncates toward zero
            biased[r] = r_t[r] + (r_t[r][SUM_W-1] ? TRUNC_BIAS : '0);
            q_c[r]    = biased[r][SUM_W-1:FRAC_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= d_c;
        end
        if (r_vld[0]) begin
            r_prod <= prod_c;
        end
        if (r_vld[1]) begin
            r_a <= a_c;
            r_b <= b_c;
        end
        if (r_vld[2]) begin
            r_t <= t_c;
        end
        if (r_vld[3]) begin
            r_q <= q_c;
        end
    end

    assign o_done = r_vld[4];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            o_q[a] = r_q[a];
        end
    end

endmodule

// ===== hw/rtl/voxel_rotate_forward_map.sv =====
// ----------------------------------------------------------------------------
// voxel_rotate_forward_map
// forward-mapped voxel rotation about a pivot into a destination volume store
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one request at a time: a place runs the 5-stage transform, then the check, address and
//  merge states with the store's read, compare and write-back; a read skips the transform
//  merge holds until the output register is free, then the next request can be taken
//  after reset a clearing pass writes zero to all VOL_DIM^3 entries
//  and no request is taken until it ends; cfg writes are taken at any time
//  a new request is taken while the last result still waits in the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_rotate_forward_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vrfm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrfm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [59:0]         i_cfg_data
);
    import vrfm_pkg::*;

    localparam logic signed [D_W-1:0] OFF_LIM = D_W'(VOL_DIM);
    localparam logic [ADDR_W-1:0]     CLR_LAST = ADDR_W'(STORE_SIZE - 1);

    // control
    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic r_out_valid;

    // configuration
    t_rows              r_rot;
    logic [PIVOT_W-1:0] r_pivot;
    logic [ROW_W-1:0]   r_lower;
    logic [ROW_W-1:0]   r_upper;
    logic [15:0]        r_empty;

    // payload
    t_in_item           r_req;
    t_q                 r_q [3];
    logic               r_in_reg;
    logic               r_in_win;
    logic [OFF_W-1:0]   r_off [3];
    logic [ADDR_W-1:0]  r_idx;
    logic [VAL_W-1:0]   r_rd_data;
    t_out_item          r_out;

    // store
    logic [VAL_W-1:0]   r_mem [STORE_SIZE];

    logic               in_acc;
    logic               cfg_acc;
    logic               xf_start;
    logic               xf_done;
    t_q_vec             xf_q;
    t_coord_vec         in_pos;
    logic               mem_re;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [VAL_W-1:0]   mem_wd;
    logic [VAL_W-1:0]   val;
    logic               ld_out;
    logic               do_write;
    logic               chk_reg;
    logic               chk_win;
    logic [OFF_W-1:0]   chk_off [3];
    logic [ADDR_W-1:0]  idx_c;
    t_out_item          res;

    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign in_pos      = {i_in_item.pos_z, i_in_item.pos_y, i_in_item.pos_x};
    assign val         = VAL_W'(r_req.src_value);

    vrfm_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (xf_start),
        .i_pos   (in_pos),
        .i_rot   (r_rot),
        .i_pivot (r_pivot),
        .o_done  (xf_done),
        .o_q     (xf_q)
    );

    // region test and store window offsets
    always_comb begin
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic signed [D_W-1:0]     off;
        chk_reg = 1'b1;
        chk_win = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo  = r_lower[COORD_W*a +: COORD_W];
            hi  = r_upper[COORD_W*a +: COORD_W];
            off = D_W'(r_q[a]) - D_W'(lo);
            chk_off[a] = off[OFF_W-1:0];
            if (r_q[a] < Q_W'(lo) || r_q[a] > Q_W'(hi)) begin
                chk_reg = 1'b0;
            end
            if (off < 0 || off >= OFF_LIM) begin
                chk_win = 1'b0;
            end
        end
    end

    assign idx_c = ADDR_W'((ADDR_W'(r_off[2]) * ADDR_W'(VOL_DIM) + ADDR_W'(r_off[1]))
                           * ADDR_W'(VOL_DIM) + ADDR_W'(r_off[0]));

    // result of the current request
    always_comb begin
        logic signed [COORD_W-1:0] sat [3];
        for (int a = 0; a < 3; a++) begin
            if (r_q[a] > Q_W'(32767)) begin
                sat[a] = 16'sh7fff;
            end else if (r_q[a] < -Q_W'(32768)) begin
                sat[a] = 16'sh8000;
            end else begin
                sat[a] = r_q[a][COORD_W-1:0];
            end
        end
        do_write      = 1'b0;
        res.dest_x    = sat[0];
        res.dest_y    = sat[1];
        res.dest_z    = sat[2];
        res.voxel_out = '0;
        if (r_req.req_type == REQ_READ) begin
            res.status = STAT_READ_DONE;
            if (r_in_win) begin
                res.voxel_out = 16'(r_rd_data);
            end
        end else if (val == VAL_W'(r_empty)) begin
            res.status = STAT_SRC_EMPTY;
            res.dest_x = '0;
            res.dest_y = '0;
            res.dest_z = '0;
        end else if (!(r_in_reg && r_in_win)) begin
            res.status = STAT_OUTSIDE;
        end else if (r_rd_data != VAL_W'(r_empty)) begin
            res.status = STAT_OCCUPIED;
        end else begin
            res.status = STAT_PLACED;
            do_write   = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        xf_start   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        mem_wd     = val;
        ld_out     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = '0;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_item.req_type == REQ_READ) begin
                        n_state = ST_CHECK;
                    end else begin
                        xf_start = 1'b1;
                        n_state  = ST_XFORM;
                    end
                end
            end
            ST_XFORM: begin
                if (xf_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                mem_re  = r_in_win;
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                // hold the read data until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    ld_out  = 1'b1;
                    mem_we  = do_write;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_rot       <= {48'd70368744177664, 48'd1073741824, 48'd16384};
            r_pivot     <= '0;
            r_lower     <= '0;
            r_upper     <= 48'd34357641247;
            r_empty     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ROT_X: r_rot[0] <= i_cfg_data[ROW_W-1:0];
                    CFG_ROT_Y: r_rot[1] <= i_cfg_data[ROW_W-1:0];
                    CFG_ROT_Z: r_rot[2] <= i_cfg_data[ROW_W-1:0];
                    CFG_PIVOT: r_pivot  <= i_cfg_data[PIVOT_W-1:0];
                    CFG_LOWER: r_lower  <= i_cfg_data[ROW_W-1:0];
                    CFG_UPPER: r_upper  <= i_cfg_data[ROW_W-1:0];
                    CFG_EMPTY: r_empty  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_item;
            for (int a = 0; a < 3; a++) begin
                r_q[a] <= Q_W'(in_pos[a]);
            end
        end
        if (r_state == ST_XFORM && xf_done) begin
            for (int a = 0; a < 3; a++) begin
                r_q[a] <= xf_q[a];
            end
        end
        if (r_state == ST_CHECK) begin
            r_in_reg <= chk_reg;
            r_in_win <= chk_win;
            r_off    <= chk_off;
        end
        if (r_state == ST_ADDR) begin
            r_idx <= idx_c;
        end
        if (ld_out) begin
            r_out <= res;
        end
    end

    // destination volume store, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[idx_c];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hw/rtl/vrfm_checker.sv =====
// ----------------------------------------------------------------------------
// vrfm_checker
// port-level checks for voxel_rotate_forward_map, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_rotate_forward_map_defines.svh"

module vrfm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input vrfm_pkg::t_out_item o_out_item
);
    import vrfm_pkg::*;

    logic in_acc;
    logic out_stall;
    logic empty_res;
    logic dest_zero;
    logic place_res;
    logic voxel_zero;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_stall  = o_out_valid && !i_out_ready;
    assign empty_res  = o_out_valid && (o_out_item.status == STAT_SRC_EMPTY);
    assign dest_zero  = (o_out_item.dest_x == '0) && (o_out_item.dest_y == '0)
                        && (o_out_item.dest_z == '0);
    assign place_res  = o_out_valid && (o_out_item.status != STAT_READ_DONE);
    assign voxel_zero = (o_out_item.voxel_out == '0);

    // a stalled result holds
    `VRFM_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_item), "stall broken")

    // one request at a time
    `VRFM_ASSERT_NEXT(a_one_at_a_time, in_acc, !o_in_ready, "second request taken while busy")

    // a skipped source carries no coordinates
    `VRFM_ASSERT_SAME(a_empty_zero, empty_res, dest_zero, "skipped source with coordinates")

    // only reads return stored data
    `VRFM_ASSERT_SAME(a_voxel_read_only, place_res, voxel_zero, "voxel data on a place result")

endmodule

bind voxel_rotate_forward_map vrfm_checker u_vrfm_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks voxel_rotate_forward_map: a directed table walks reset state, store
// edges, occupancy and saturation, then random phases with fresh settings
// compare every result against an in-bench rotation and volume store mirror
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import vrfm_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 175;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 150000;
    localparam int SETTLE_CYCLES = 20;
    localparam int SHOWN_FAULTS  = 10;

    // index past the last register, writes to it must change nothing
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [59:0] reg_data;
        t_in_item    req;
        logic        known;
        t_out_item   want;
    } t_step;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;

    // mirror of the block's settings and destination volume
    logic [47:0] rot_rows [3];
    logic [59:0] pivot_reg;
    logic [47:0] region_lo;
    logic [47:0] region_hi;
    logic [15:0] empty_val;
    logic [15:0] mirror_volume [STORE_SIZE];

    t_out_item   due_results [$];
    t_step       plan [$];
    t_out_item   head_result;
    int          fault_count = 0;
    int          quiet_cycles = 0;
    bit          no_gaps = 1'b0;
    bit          hold_off_req = 1'b0;

    voxel_rotate_forward_map u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint lower_at(input int a);
        return $signed(region_lo[16*a +: 16]);
    endfunction

    function automatic longint pivot_at(input int a);
        return $signed(pivot_reg[20*a +: 20]);
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v > 32767) begin
            return 16'h7fff;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return 16'(v);
    endfunction

    // -1 when the point falls outside the store window
    function automatic int store_slot(input longint x, y, z);
        longint ox;
        longint oy;
        longint oz;
        ox = x - lower_at(0);
        oy = y - lower_at(1);
        oz = z - lower_at(2);
        if (ox < 0 || oy < 0 || oz < 0 || ox >= VOL_DIM || oy >= VOL_DIM || oz >= VOL_DIM) begin
            return -1;
        end
        return int'((oz * VOL_DIM + oy) * VOL_DIM + ox);
    endfunction

    function automatic t_out_item map_voxel(input t_in_item req);
        t_out_item res;
        longint    p [3];
        longint    q [3];
        longint    dv [3];
        longint    acc;
        int        slot;
        bit        in_region;
        res = '0;
        p[0] = $signed(req.pos_x);
        p[1] = $signed(req.pos_y);
        p[2] = $signed(req.pos_z);
        if (req.req_type == REQ_READ) begin
            res.status = STAT_READ_DONE;
            res.dest_x = req.pos_x;
            res.dest_y = req.pos_y;
            res.dest_z = req.pos_z;
            slot = store_slot(p[0], p[1], p[2]);
            if (slot >= 0) begin
                res.voxel_out = mirror_volume[slot];
            end
            return res;
        end
        if (req.src_value == empty_val) begin
            res.status = STAT_SRC_EMPTY;
            return res;
        end
        // q = R * (16p - pivot) + pivot * 2^14, all in Q.18, then truncate
        for (int a = 0; a < 3; a++) begin
            dv[a] = p[a] * 16 - pivot_at(a);
        end
        for (int r = 0; r < 3; r++) begin
            acc = pivot_at(r) * (longint'(1) << PIV_SH);
            for (int c = 0; c < 3; c++) begin
                acc += longint'($signed(rot_rows[r][16*c +: 16])) * dv[c];
            end
            q[r] = acc / (longint'(1) << FRAC_SH);
        end
        res.dest_x = sat16(q[0]);
        res.dest_y = sat16(q[1]);
        res.dest_z = sat16(q[2]);
        // region test on the unsaturated point
        in_region = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (q[a] < lower_at(a) || q[a] > longint'($signed(region_hi[16*a +: 16]))) begin
                in_region = 1'b0;
            end
        end
        slot = store_slot(q[0], q[1], q[2]);
        if (!in_region || slot < 0) begin
            res.status = STAT_OUTSIDE;
        end else if (mirror_volume[slot] == empty_val) begin
            mirror_volume[slot] = req.src_value;
            res.status = STAT_PLACED;
        end else begin
            res.status = STAT_OCCUPIED;
        end
        return res;
    endfunction

    function automatic t_step reg_row(input logic [2:0] idx, input logic [59:0] data);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic t_step req_row(input logic kind, input int x, y, z,
                                      input logic [15:0] v);
        t_step s;
        s = '0;
        s.req.req_type = kind;
        s.req.pos_x = 16'(x);
        s.req.pos_y = 16'(y);
        s.req.pos_z = 16'(z);
        s.req.src_value = v;
        return s;
    endfunction

    function automatic t_step with_result(input t_step s, input t_status st, input int x, y, z,
                                          input logic [15:0] v);
        s.known = 1'b1;
        s.want.status = st;
        s.want.dest_x = 16'(x);
        s.want.dest_y = 16'(y);
        s.want.dest_z = 16'(z);
        s.want.voxel_out = v;
        return s;
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int       spread;
        int       pick;
        it.req_type = ($urandom_range(0, 99) < 25) ? REQ_READ : REQ_PLACE;
        // mostly a tight cube near the region so places collide and occupy
        spread = $urandom_range(0, 1) ? 9 : 37;
        it.pos_x = 16'(lower_at(0) + longint'($urandom_range(0, spread)) - 2);
        it.pos_y = 16'(lower_at(1) + longint'($urandom_range(0, spread)) - 2);
        it.pos_z = 16'(lower_at(2) + longint'($urandom_range(0, spread)) - 2);
        if ($urandom_range(0, 99) < 12) begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it.src_value = empty_val;
        end else if (pick < 28) begin
            it.src_value = 16'hffff;
        end else if (pick < 33) begin
            it.src_value = 16'h0000;
        end else begin
            it.src_value = 16'($urandom);
        end
        return it;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_request(input t_in_item it, input logic use_typed,
                                input t_out_item typed_want);
        t_out_item predicted;
        while (!no_gaps && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        predicted = map_voxel(it);
        due_results.push_back(use_typed ? typed_want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        case (idx)
            CFG_ROT_X: rot_rows[0] = data[47:0];
            CFG_ROT_Y: rot_rows[1] = data[47:0];
            CFG_ROT_Z: rot_rows[2] = data[47:0];
            CFG_PIVOT: pivot_reg = data;
            CFG_LOWER: region_lo = data[47:0];
            CFG_UPPER: region_hi = data[47:0];
            CFG_EMPTY: empty_val = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic load_random_setting(input int phase);
        logic [47:0] rows [3];
        logic [47:0] lo_reg;
        logic [47:0] hi_reg;
        logic [59:0] piv_reg;
        logic [15:0] empty_reg;
        longint      lo [3];
        int          axis_of [3];
        int          tmp;
        int          j;
        int          mat_pick;
        int          hi_pick;
        int          pick;
        // signed axis permutation, near-rotation coefficients, or anything
        axis_of[0] = 0;
        axis_of[1] = 1;
        axis_of[2] = 2;
        j = $urandom_range(0, 2);
        tmp = axis_of[0];
        axis_of[0] = axis_of[j];
        axis_of[j] = tmp;
        j = $urandom_range(1, 2);
        tmp = axis_of[1];
        axis_of[1] = axis_of[j];
        axis_of[j] = tmp;
        mat_pick = $urandom_range(0, 9);
        for (int r = 0; r < 3; r++) begin
            rows[r] = '0;
            for (int c = 0; c < 3; c++) begin
                if (mat_pick < 5) begin
                    if (c == axis_of[r]) begin
                        rows[r][16*c +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
                    end
                end else if (mat_pick < 8) begin
                    rows[r][16*c +: 16] = 16'(longint'($urandom_range(0, 32768)) - 16384);
                end else begin
                    rows[r][16*c +: 16] = 16'($urandom);
                end
            end
        end
        hi_pick = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 9) == 0) begin
                lo[a] = $signed(16'($urandom));
            end else begin
                lo[a] = longint'($urandom_range(0, 128)) - 64;
            end
            lo_reg[16*a +: 16] = 16'(lo[a]);
            if (hi_pick < 70) begin
                hi_reg[16*a +: 16] = 16'(lo[a] + 31);
            end else if (hi_pick < 85) begin
                hi_reg[16*a +: 16] = 16'(lo[a] + longint'($urandom_range(0, 40)));
            end else begin
                hi_reg[16*a +: 16] = 16'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                piv_reg[20*a +: 20] = 20'($urandom);
            end else begin
                piv_reg[20*a +: 20] = 20'((lo[a] + longint'($urandom_range(0, 31))) * 16
                                          + longint'($urandom_range(0, 15)));
            end
        end
        pick = $urandom_range(0, 99);
        if (phase == 1 || (pick >= 60 && pick < 75)) begin
            empty_reg = 16'hffff;
        end else if (pick < 60) begin
            empty_reg = 16'h0000;
        end else begin
            empty_reg = 16'($urandom);
        end
        write_reg(CFG_ROT_X, 60'(rows[0]));
        write_reg(CFG_ROT_Y, 60'(rows[1]));
        write_reg(CFG_ROT_Z, 60'(rows[2]));
        write_reg(CFG_PIVOT, piv_reg);
        write_reg(CFG_LOWER, 60'(lo_reg));
        write_reg(CFG_UPPER, 60'(hi_reg));
        write_reg(CFG_EMPTY, 60'(empty_reg));
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int held;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(negedge clk);
                end
                hold_off_req = 1'b0;
            end else begin
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS) begin
                    $display("unexpected transaction: status %0d dest (%0d,%0d,%0d) voxel %h",
                             out_item.status, out_item.dest_x, out_item.dest_y,
                             out_item.dest_z, out_item.voxel_out);
                end
            end else begin
                head_result = due_results.pop_front();
                if (head_result.status !== out_item.status
                        || head_result.dest_x !== out_item.dest_x
                        || head_result.dest_y !== out_item.dest_y
                        || head_result.dest_z !== out_item.dest_z
                        || head_result.voxel_out !== out_item.voxel_out) begin
                    fault_count++;
                    if (fault_count <= SHOWN_FAULTS) begin
                        $display("mismatch at %0t: status exp %0d got %0d", $realtime,
                                 head_result.status, out_item.status);
                        $display("  dest exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                 head_result.dest_x, head_result.dest_y, head_result.dest_z,
                                 out_item.dest_x, out_item.dest_y, out_item.dest_z);
                        $display("  voxel exp %h got %h", head_result.voxel_out,
                                 out_item.voxel_out);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction, covers the clearing pass
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rot_rows[0] = 48'h0000_0000_4000;
        rot_rows[1] = 48'h0000_4000_0000;
        rot_rows[2] = 48'h4000_0000_0000;
        pivot_reg = '0;
        region_lo = '0;
        region_hi = 48'h0007_ffe0_001f;
        empty_val = '0;
        foreach (mirror_volume[i]) begin
            mirror_volume[i] = '0;
        end

        // reset region has y upper below y lower, so every non-empty place lands outside
        plan.push_back(with_result(req_row(REQ_PLACE, 0, 0, 0, 16'h0005),
                                   STAT_OUTSIDE, 0, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, -32768, 32767, 1, 16'h0000),
                                   STAT_SRC_EMPTY, 0, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_READ, 0, 0, 0, 16'h0000),
                                   STAT_READ_DONE, 0, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_READ, -32768, 32767, -1, 16'hffff),
                                   STAT_READ_DONE, -32768, 32767, -1, 16'h0000));
        // region wider than the store on x
        plan.push_back(reg_row(CFG_UPPER, 60'h001f_001f_0028));
        plan.push_back(reg_row(CFG_UNUSED, 60'hfff_ffff_ffff_ffff));
        plan.push_back(with_result(req_row(REQ_PLACE, 1, 2, 3, 16'hffff),
                                   STAT_PLACED, 1, 2, 3, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, 1, 2, 3, 16'h0007),
                                   STAT_OCCUPIED, 1, 2, 3, 16'h0000));
        plan.push_back(with_result(req_row(REQ_READ, 1, 2, 3, 16'h0000),
                                   STAT_READ_DONE, 1, 2, 3, 16'hffff));
        plan.push_back(with_result(req_row(REQ_PLACE, 35, 0, 0, 16'h0001),
                                   STAT_OUTSIDE, 35, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, -1, 0, 0, 16'h0001),
                                   STAT_OUTSIDE, -1, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, 31, 31, 31, 16'h8000),
                                   STAT_PLACED, 31, 31, 31, 16'h0000));
        plan.push_back(with_result(req_row(REQ_READ, 31, 31, 31, 16'h0000),
                                   STAT_READ_DONE, 31, 31, 31, 16'h8000));
        plan.push_back(with_result(req_row(REQ_READ, 32, 31, 31, 16'h0000),
                                   STAT_READ_DONE, 32, 31, 31, 16'h0000));
        // nonzero empty value: zero becomes a real voxel
        plan.push_back(reg_row(CFG_EMPTY, 60'h8000));
        plan.push_back(with_result(req_row(REQ_PLACE, 31, 31, 31, 16'h1234),
                                   STAT_PLACED, 31, 31, 31, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, 5, 5, 5, 16'h8000),
                                   STAT_SRC_EMPTY, 0, 0, 0, 16'h0000));
        plan.push_back(with_result(req_row(REQ_PLACE, 0, 0, 0, 16'h0000),
                                   STAT_OCCUPIED, 0, 0, 0, 16'h0000));
        // most negative coefficients and pivot, widest region
        plan.push_back(reg_row(CFG_ROT_X, 60'h8000_8000_8000));
        plan.push_back(reg_row(CFG_ROT_Y, 60'h8000_8000_8000));
        plan.push_back(reg_row(CFG_ROT_Z, 60'h8000_8000_8000));
        plan.push_back(reg_row(CFG_PIVOT, 60'h80000_80000_80000));
        plan.push_back(reg_row(CFG_LOWER, 60'h8000_8000_8000));
        plan.push_back(reg_row(CFG_UPPER, 60'h7fff_7fff_7fff));
        plan.push_back(req_row(REQ_PLACE, 32767, 32767, 32767, 16'h0001));
        plan.push_back(req_row(REQ_PLACE, -32768, -32768, -32768, 16'h0001));
        plan.push_back(req_row(REQ_PLACE, -32768, 32767, 0, 16'h0001));
        // most positive coefficients and pivot
        plan.push_back(reg_row(CFG_ROT_X, 60'h7fff_7fff_7fff));
        plan.push_back(reg_row(CFG_ROT_Y, 60'h7fff_7fff_7fff));
        plan.push_back(reg_row(CFG_ROT_Z, 60'h7fff_7fff_7fff));
        plan.push_back(reg_row(CFG_PIVOT, 60'h7ffff_7ffff_7ffff));
        plan.push_back(req_row(REQ_PLACE, 32767, 32767, 32767, 16'h0001));
        plan.push_back(req_row(REQ_PLACE, -32768, -32768, -32768, 16'h0001));
        plan.push_back(req_row(REQ_READ, -32768, -32768, -32768, 16'h0000));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drain();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_request(plan[i].req, plan[i].known, plan[i].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drain();
            load_random_setting(phase);
            no_gaps = (phase == 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // output held off while requests keep coming
                if (phase == 4 && n == 40) begin
                    hold_off_req = 1'b1;
                end
                // sender stops until the block is empty
                if (phase == 6 && n == PHASE_ITEMS / 2) begin
                    wait_drain();
                end
                send_request(random_request(), 1'b0, '0);
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
